FILE: rtl/vsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and constants of the base-128 varint stream decoder.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned SHIFT_W    = 6;
    localparam int unsigned GROUP_W    = 7;

    localparam logic [COUNT_W-1:0] MAX_CONT = 4'd9;

    localparam int unsigned CONT_BIT   = 7;
    localparam int unsigned SIGN_BIT   = 6;

    localparam logic [7:0] MASK_UNSIGNED = 8'h7f;
    localparam logic [7:0] MASK_SIGNED   = 8'h3f;

    typedef struct packed {
        logic                   emit;
        logic                   overlong;
        logic [VALUE_W-1:0]     value;
        logic [VALUE_W-1:0]     acc_next;
        logic [COUNT_W-1:0]     count_next;
    } vsd_step_t;

    function automatic logic [SHIFT_W-1:0] shift_of(input logic [COUNT_W-1:0] count);
        logic [SHIFT_W+1:0] times_eight;
        logic [SHIFT_W+1:0] times_seven;
        begin
            times_eight = {1'b0, count, 3'b000};
            times_seven = times_eight - {4'b0000, count};
            return times_seven[SHIFT_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/vsd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_decode
// One decode step: folds a byte into the accumulator or finishes a number.
// ----------------------------------------------------------------------------
module vsd_decode
(
    input  logic [7:0]                        byte_in,
    input  logic                              signed_mode,
    input  logic [vsd_pkg::VALUE_W-1:0]       acc,
    input  logic [vsd_pkg::COUNT_W-1:0]       count,
    output vsd_pkg::vsd_step_t                step
);
    import vsd_pkg::*;

    logic [COUNT_W-1:0] count_sat;
    logic [SHIFT_W-1:0] shift;
    logic [7:0]         group;
    logic [VALUE_W-1:0] placed;
    logic [VALUE_W-1:0] merged;

    always_comb
    begin
        count_sat = (count > MAX_CONT) ? MAX_CONT : count;
        shift     = shift_of(count_sat);

        if (byte_in[CONT_BIT] || !signed_mode)
        begin
            group = byte_in & MASK_UNSIGNED;
        end
        else
        begin
            group = byte_in & MASK_SIGNED;
        end

        placed = {{(VALUE_W-8){1'b0}}, group} << shift;
        merged = acc | placed;

        step            = '0;
        step.acc_next   = acc;
        step.count_next = count_sat;

        if (byte_in[CONT_BIT])
        begin
            if (count_sat >= MAX_CONT)
            begin
                // drop overlong number
                step.emit       = 1'b1;
                step.overlong   = 1'b1;
                step.value      = '0;
                step.acc_next   = '0;
                step.count_next = '0;
            end
            else
            begin
                step.acc_next   = merged;
                step.count_next = count_sat + 4'd1;
            end
        end
        else
        begin
            step.emit       = 1'b1;
            step.overlong   = 1'b0;
            step.value      = (signed_mode && byte_in[SIGN_BIT]) ? (~merged + 64'd1) : merged;
            step.acc_next   = '0;
            step.count_next = '0;
        end
    end

endmodule

FILE: rtl/varint_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_stream_decoder_top
// Base-128 varint decoder, one byte per request, unsigned or sign-magnitude.
// A result passes from the byte register through the decode into the result
// register. Throughput: one byte per cycle while the output is not stalled, set
// by the single-pass decode between the byte register and the result register.
// Reset: rst_n clears the number in progress, both stages and signed_mode.
// ----------------------------------------------------------------------------
module varint_stream_decoder_top
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    byte_in,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vsd_pkg::VALUE_W-1:0]   value,
    output logic                          overlong_error
);
    import vsd_pkg::*;

    logic                 signed_mode_reg;
    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic [VALUE_W-1:0]   acc_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 overlong_reg;

    vsd_step_t            step;
    logic                 out_free;
    logic                 advance;

    vsd_decode u_decode
    (
        .byte_in     (byte_reg),
        .signed_mode (signed_mode_reg),
        .acc         (acc_reg),
        .count       (count_reg),
        .step        (step)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!step.emit || out_free);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            signed_mode_reg <= cfg_wr_data;
        end
    end

    // byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= byte_in;
        end
    end

    // number in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg   <= step.acc_next;
            count_reg <= step.count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.emit)
        begin
            value_reg    <= step.value;
            overlong_reg <= step.overlong;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = value_reg;
    assign overlong_error = overlong_reg;

endmodule
